// ----- src/hsfd_pkg.sv -----
// Shared constants, types and helpers for the humidity sensor frame decoder.
package hsfd_pkg;

    localparam int FRAME_BITS = 40;
    localparam int IDX_W      = 6;
    localparam logic [IDX_W-1:0] LAST_BIT_IDX = IDX_W'(FRAME_BITS - 1);

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_THRESHOLD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_HUM_ALPHA  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_TEMP_ALPHA = 2'd2;
    localparam int CFG_DATA_W = 9;

    localparam logic signed [7:0] THRESHOLD_RESET = 8'sd30;
    localparam logic [8:0]        ALPHA_RESET     = 9'd128;

    localparam logic [14:0]        MAG_MASK = 15'h7FFF;
    localparam logic signed [19:0] SAT_MAX  = 20'sd32767;
    localparam logic signed [19:0] SAT_MIN  = -20'sd32768;

    // Divide by ten: multiply by ceil(2^19 / 10), exact for magnitudes up to 2^15
    localparam logic [15:0] RECIP_TEN   = 16'd52429;
    localparam int          RECIP_SHIFT = 19;

    localparam int TDATA_IN_W   = 8;
    localparam int TDATA_OUT_W  = 72;
    localparam int TDATA_OUT_PAD = TDATA_OUT_W - 66;

    typedef struct packed {
        logic               ok;
        logic signed [15:0] hum;
        logic signed [15:0] temp;
        logic [7:0]         fails;
    } result_t;

endpackage

// ----- src/humidity_sensor_frame_decoder_unit.sv -----
// Top level of the humidity sensor frame decoder: config registers and stage wiring.
// Throughput: one pulse transfer per cycle; s_axis_tready drops only when a pulse
//   that may close a frame meets a completed frame still held behind a full pipeline.
// A result reaches m_axis through the frame register, checksum/multiply stage, filter
//   snapshot and divide-by-ten register after the transfer of the fortieth bit.
// Pulses that do not close a frame produce no result.
// Reset (asynchronous, rst_n low): bit count, filter state, seed flag, error count and
//   all valid flags cleared; threshold 30, both alphas 128.
module humidity_sensor_frame_decoder_unit
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [hsfd_pkg::TDATA_IN_W-1:0]     s_axis_tdata,  // [7:0] pulse_width
    input  logic                                s_axis_tuser,  // [0] frame_start
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [15:0] humidity_tenths, [31:16] temperature_tenths, [44:32] humidity_whole,
    // [57:45] temperature_whole, [65:58] error_count, [71:66] zero
    output logic [hsfd_pkg::TDATA_OUT_W-1:0]    m_axis_tdata,
    output logic                                m_axis_tuser,  // [0] checksum_ok
    input  logic                                cfg_we,
    input  logic [hsfd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [hsfd_pkg::CFG_DATA_W-1:0]     cfg_data
);

    logic signed [7:0] threshold_reg;
    logic [8:0]        hum_alpha_reg;
    logic [8:0]        temp_alpha_reg;

    logic                            frame_valid;
    logic                            frame_ready;
    logic [hsfd_pkg::FRAME_BITS-1:0] frame;
    logic                            res_valid;
    logic                            res_ready;
    hsfd_pkg::result_t               res;

    // Configuration writes; unused indexes are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg  <= hsfd_pkg::THRESHOLD_RESET;
            hum_alpha_reg  <= hsfd_pkg::ALPHA_RESET;
            temp_alpha_reg <= hsfd_pkg::ALPHA_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                hsfd_pkg::CFG_IDX_THRESHOLD:  threshold_reg  <= cfg_data[7:0];
                hsfd_pkg::CFG_IDX_HUM_ALPHA:  hum_alpha_reg  <= cfg_data;
                hsfd_pkg::CFG_IDX_TEMP_ALPHA: temp_alpha_reg <= cfg_data;
                default:                      ;
            endcase
        end
    end

    // Pulse slicing and frame assembly
    hsfd_frame_shift u_shift
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .pulse       (s_axis_tdata),
        .start       (s_axis_tuser),
        .threshold   (threshold_reg),
        .frame_valid (frame_valid),
        .frame_ready (frame_ready),
        .frame       (frame)
    );

    // Checksum, decode, filter, held state and error count
    hsfd_filter u_filter
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .frame_valid (frame_valid),
        .frame_ready (frame_ready),
        .frame       (frame),
        .hum_alpha   (hum_alpha_reg),
        .temp_alpha  (temp_alpha_reg),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res)
    );

    // Whole units and the output register
    hsfd_out u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_ok    (m_axis_tuser),
        .out_data  (m_axis_tdata)
    );

    // A good frame always reports a cleared error count
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> (m_axis_tdata[65:58] == 8'd0))
        else $error("good frame with non-zero error count");

    // A bad frame always reports at least one failure
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> (m_axis_tdata[65:58] != 8'd0))
        else $error("bad frame with zero error count");

    // Whole units keep the sign of the tenths
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[44:32] != 13'd0) |->
            (m_axis_tdata[44] == m_axis_tdata[15]))
        else $error("humidity whole units sign mismatch");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[57:45] != 13'd0) |->
            (m_axis_tdata[57] == m_axis_tdata[31]))
        else $error("temperature whole units sign mismatch");

endmodule

// ----- src/hsfd_frame_shift.sv -----
// Bit slicer and 40-bit frame assembly with a one-entry frame register.
module hsfd_frame_shift
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic signed [7:0]      pulse,
    input  logic                   start,
    input  logic signed [7:0]      threshold,
    output logic                   frame_valid,
    input  logic                   frame_ready,
    output logic [hsfd_pkg::FRAME_BITS-1:0] frame
);

    logic [hsfd_pkg::IDX_W-1:0]      bit_index_reg;
    logic [hsfd_pkg::IDX_W-1:0]      idx_base;
    logic [hsfd_pkg::FRAME_BITS-1:0] shift_reg;
    logic [hsfd_pkg::FRAME_BITS-1:0] shift_base;
    logic [hsfd_pkg::FRAME_BITS-1:0] shift_next;
    logic [hsfd_pkg::FRAME_BITS-1:0] frame_reg;
    logic                            frame_valid_reg;
    logic                            accept;
    logic                            complete;

    assign idx_base   = start ? '0 : bit_index_reg;
    assign shift_base = start ? '0 : shift_reg;
    assign shift_next = {shift_base[hsfd_pkg::FRAME_BITS-2:0], (pulse > threshold)};
    assign complete   = (idx_base == hsfd_pkg::LAST_BIT_IDX);

    // Only a pulse that may close a frame needs the frame register free
    assign in_ready = (bit_index_reg != hsfd_pkg::LAST_BIT_IDX) || !frame_valid_reg
                      || frame_ready;
    assign accept   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_index_reg   <= '0;
            shift_reg       <= '0;
            frame_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                shift_reg     <= shift_next;
                bit_index_reg <= complete ? '0 : idx_base + 1'b1;
            end
            if (accept && complete)
                frame_valid_reg <= 1'b1;
            else if (frame_ready)
                frame_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && complete)
            frame_reg <= shift_next;
    end

    assign frame_valid = frame_valid_reg;
    assign frame       = frame_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (bit_index_reg == hsfd_pkg::LAST_BIT_IDX) && frame_valid_reg)
        else $error("frame slicer stalled without a pending frame");

    assert property (@(posedge clk) disable iff (!rst_n)
        accept && complete |=> frame_valid_reg && (bit_index_reg == '0))
        else $error("completed frame not captured");

    assert property (@(posedge clk) disable iff (!rst_n)
        bit_index_reg <= hsfd_pkg::LAST_BIT_IDX)
        else $error("bit index out of range");

endmodule

// ----- src/hsfd_filter.sv -----
// Checksum, decode and one-pole low-pass filter with held values and error count.
module hsfd_filter
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            frame_valid,
    output logic                            frame_ready,
    input  logic [hsfd_pkg::FRAME_BITS-1:0] frame,
    input  logic [8:0]                      hum_alpha,
    input  logic [8:0]                      temp_alpha,
    output logic                            res_valid,
    input  logic                            res_ready,
    output hsfd_pkg::result_t               res
);

    logic [15:0]        hraw;
    logic [15:0]        traw;
    logic [7:0]         csum;
    logic               ok_dec;
    logic signed [15:0] xh_dec;
    logic signed [15:0] xt_dec;
    logic signed [16:0] diff_h;
    logic signed [16:0] diff_t;

    logic               s2_valid_reg;
    logic               ok_reg;
    logic signed [15:0] xh_reg;
    logic signed [15:0] xt_reg;
    logic signed [26:0] prod_h_reg;
    logic signed [26:0] prod_t_reg;

    logic signed [15:0] held_h_reg;
    logic signed [15:0] held_t_reg;
    logic               seeded_reg;
    logic [7:0]         fail_reg;
    logic [7:0]         fail_next;

    logic signed [15:0] yh;
    logic signed [15:0] yt;
    logic               load;
    logic               adv;

    function automatic logic signed [15:0] lp_out(input logic signed [15:0] x,
                                                  input logic signed [26:0] prod);
        logic signed [27:0] num;
        logic signed [27:0] adj;
        logic signed [19:0] y;
        begin
            num = {{4{x[15]}}, x, 8'b0} + {prod[26], prod};
            // round toward zero before the arithmetic shift
            adj = num + (num[27] ? 28'sd255 : 28'sd0);
            y   = adj[27:8];
            if (y > hsfd_pkg::SAT_MAX)
                lp_out = 16'sh7FFF;
            else if (y < hsfd_pkg::SAT_MIN)
                lp_out = 16'sh8000;
            else
                lp_out = y[15:0];
        end
    endfunction

    assign hraw   = frame[39:24];
    assign traw   = frame[23:8];
    assign csum   = frame[7:0];
    assign ok_dec = ((hraw[7:0] + hraw[15:8] + traw[7:0] + traw[15:8]) == csum);
    assign xh_dec = hraw;
    // sign-magnitude temperature
    assign xt_dec = traw[15] ? -$signed({1'b0, traw[14:0] & hsfd_pkg::MAG_MASK})
                             : $signed(traw);
    assign diff_h = {held_h_reg[15], held_h_reg} - {xh_dec[15], xh_dec};
    assign diff_t = {held_t_reg[15], held_t_reg} - {xt_dec[15], xt_dec};

    // load only into an empty stage so the held values are final for this frame
    assign frame_ready = !s2_valid_reg;
    assign load        = frame_valid && frame_ready;
    assign adv         = s2_valid_reg && res_ready;

    assign yh = seeded_reg ? lp_out(xh_reg, prod_h_reg) : xh_reg;
    assign yt = seeded_reg ? lp_out(xt_reg, prod_t_reg) : xt_reg;
    assign fail_next = ok_reg ? 8'd0 : ((fail_reg == 8'hFF) ? fail_reg : fail_reg + 8'd1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            held_h_reg   <= '0;
            held_t_reg   <= '0;
            seeded_reg   <= 1'b0;
            fail_reg     <= '0;
        end
        else
        begin
            if (load)
                s2_valid_reg <= 1'b1;
            else if (adv)
                s2_valid_reg <= 1'b0;
            if (adv)
            begin
                fail_reg <= fail_next;
                if (ok_reg)
                begin
                    held_h_reg <= yh;
                    held_t_reg <= yt;
                    seeded_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            ok_reg     <= ok_dec;
            xh_reg     <= xh_dec;
            xt_reg     <= xt_dec;
            prod_h_reg <= 27'($signed({1'b0, hum_alpha})) * 27'(diff_h);
            prod_t_reg <= 27'($signed({1'b0, temp_alpha})) * 27'(diff_t);
        end
    end

    assign res_valid  = s2_valid_reg;
    assign res.ok     = ok_reg;
    assign res.hum    = ok_reg ? yh : held_h_reg;
    assign res.temp   = ok_reg ? yt : held_t_reg;
    assign res.fails  = fail_next;

endmodule

// ----- src/hsfd_out.sv -----
// Result snapshot, divide-by-ten and output register.
module hsfd_out
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   res_valid,
    output logic                                   res_ready,
    input  hsfd_pkg::result_t                      res,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic                                   out_ok,
    output logic [hsfd_pkg::TDATA_OUT_W-1:0]       out_data
);

    hsfd_pkg::result_t  st_reg;
    logic               st_valid_reg;
    logic               st_ready;
    logic               m_valid_reg;
    logic               m_ok_reg;
    logic signed [15:0] m_hum_reg;
    logic signed [15:0] m_temp_reg;
    logic signed [12:0] m_hw_reg;
    logic signed [12:0] m_tw_reg;
    logic [7:0]         m_err_reg;

    function automatic logic signed [12:0] div_ten(input logic signed [15:0] v);
        logic [16:0] mag;
        logic [32:0] prod;
        logic [12:0] q;
        begin
            mag  = v[15] ? 17'(-$signed({v[15], v})) : {1'b0, v};
            prod = 33'(mag) * 33'(hsfd_pkg::RECIP_TEN);
            q    = prod[hsfd_pkg::RECIP_SHIFT+12:hsfd_pkg::RECIP_SHIFT];
            div_ten = v[15] ? -$signed(q) : $signed(q);
        end
    endfunction

    assign st_ready  = !m_valid_reg || out_ready;
    assign res_ready = !st_valid_reg || st_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            if (res_ready)
                st_valid_reg <= res_valid;
            if (st_ready)
                m_valid_reg <= st_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
            st_reg <= res;
        if (st_ready && st_valid_reg)
        begin
            m_ok_reg   <= st_reg.ok;
            m_hum_reg  <= st_reg.hum;
            m_temp_reg <= st_reg.temp;
            m_hw_reg   <= div_ten(st_reg.hum);
            m_tw_reg   <= div_ten(st_reg.temp);
            m_err_reg  <= st_reg.fails;
        end
    end

    assign out_valid = m_valid_reg;
    assign out_ok    = m_ok_reg;
    assign out_data  = {{hsfd_pkg::TDATA_OUT_PAD{1'b0}}, m_err_reg, m_tw_reg, m_hw_reg,
                        m_temp_reg, m_hum_reg};

endmodule

// ----- test/tb.sv -----
// Self-checking testbench for the humidity sensor frame decoder.
module tb;

    localparam int RESET_CYCLES  = 9;
    localparam int SETTLE_CYCLES = 8;     // lets the pipeline empty; leave some margin
    localparam int HOLD_CYCLES   = 400;
    localparam int QUIET_LIMIT   = 4000;

    // One decoded frame as it leaves the block
    typedef struct packed {
        logic        ok;
        logic [15:0] hum;
        logic [15:0] temp;
        logic [12:0] hum_whole;
        logic [12:0] temp_whole;
        logic [7:0]  fails;
    } reading_t;

    logic                               clk           = 1'b0;
    logic                               rst_n         = 1'b0;
    logic                               s_axis_tvalid = 1'b0;
    logic                               s_axis_tready;
    logic [hsfd_pkg::TDATA_IN_W-1:0]    s_axis_tdata  = '0;
    logic                               s_axis_tuser  = 1'b0;
    logic                               m_axis_tvalid;
    logic                               m_axis_tready = 1'b0;
    logic [hsfd_pkg::TDATA_OUT_W-1:0]   m_axis_tdata;
    logic                               m_axis_tuser;
    logic                               cfg_we        = 1'b0;
    logic [hsfd_pkg::CFG_IDX_W-1:0]     cfg_index     = '0;
    logic [hsfd_pkg::CFG_DATA_W-1:0]    cfg_data      = '0;

    // Mirror of the decoder state and its registers
    logic [5:0]               bits_seen    = '0;
    logic [39:0]              shift_bits   = '0;
    longint                   held_hum     = 0;
    longint                   held_temp    = 0;
    bit                       seeded_flag  = 1'b0;
    logic [7:0]               fail_run     = '0;
    logic signed [7:0]        one_above    = hsfd_pkg::THRESHOLD_RESET;
    logic [8:0]               hum_alpha    = hsfd_pkg::ALPHA_RESET;
    logic [8:0]               temp_alpha   = hsfd_pkg::ALPHA_RESET;

    reading_t                 expected_readings[$];

    int                       send_idle_pct  = 0;
    int                       recv_stall_pct = 0;
    int                       hold_len       = 0;
    int                       hold_req       = 0;
    int                       hold_ack       = 0;
    int                       hold_left      = 0;

    int                       mismatches     = 0;
    int                       pulses_sent    = 0;
    int                       frames_closed  = 0;
    int                       good_seen      = 0;
    int                       bad_seen       = 0;
    int                       stall_cycles   = 0;
    int                       quiet_cycles   = 0;

    humidity_sensor_frame_decoder_unit uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [7:0] pulse_width
        .s_axis_tuser  (s_axis_tuser),   // [0] frame_start
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        // [15:0] hum tenths, [31:16] temp tenths, [44:32] hum whole,
        // [57:45] temp whole, [65:58] error count, [71:66] zero
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),   // [0] checksum_ok
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #2 clk = ~clk;

    // ---------------------------------------------------------------- predictor

    // One-pole low-pass, sum truncated toward zero, clamped to 16 bits signed
    function automatic longint smooth(input longint x, input longint prev, input longint alpha);
        longint y;
        y = (x * 256 + alpha * (prev - x)) / 256;
        if (y > 32767)
            y = 32767;
        else if (y < -32768)
            y = -32768;
        return y;
    endfunction

    // Shift one pulse into the mirror; on the fortieth bit queue the reading
    function void decode_pulse(input logic [7:0] pw, input logic start);
        logic [15:0] hraw;
        logic [15:0] traw;
        logic [7:0]  sum;
        longint      h;
        longint      t;
        reading_t    r;
        if (start)
        begin
            bits_seen  = '0;
            shift_bits = '0;
        end
        shift_bits = {shift_bits[38:0], ($signed(pw) > one_above)};
        bits_seen  = bits_seen + 6'd1;
        if (bits_seen < hsfd_pkg::FRAME_BITS)
            return;
        bits_seen = '0;
        hraw = shift_bits[39:24];
        traw = shift_bits[23:8];
        sum  = hraw[7:0] + hraw[15:8] + traw[7:0] + traw[15:8];
        r.ok = (sum == shift_bits[7:0]);
        if (r.ok)
        begin
            h = longint'($signed(hraw));
            // temperature is sign-magnitude on the wire
            t = traw[15] ? -longint'(traw[14:0]) : longint'(traw);
            if (!seeded_flag)
            begin
                held_hum    = h;
                held_temp   = t;
                seeded_flag = 1'b1;
            end
            else
            begin
                held_hum  = smooth(h, held_hum, longint'(hum_alpha));
                held_temp = smooth(t, held_temp, longint'(temp_alpha));
            end
            fail_run = '0;
        end
        else if (fail_run != 8'hFF)
            fail_run = fail_run + 8'd1;
        r.hum        = held_hum[15:0];
        r.temp       = held_temp[15:0];
        r.hum_whole  = 13'(held_hum / 10);
        r.temp_whole = 13'(held_temp / 10);
        r.fails      = fail_run;
        expected_readings.push_back(r);
        frames_closed++;
    endfunction

    // ---------------------------------------------------------------- stimulus helpers

    // Pulse width that lands on the wanted side of the threshold; sometimes right at the edge
    function automatic logic [7:0] pulse_for(input bit one);
        int lo;
        int hi;
        if (one && one_above != 8'sd127)
        begin
            lo = int'(one_above) + 1;
            hi = 127;
        end
        else
        begin
            lo = -128;
            hi = int'(one_above);
        end
        case ($urandom_range(7))
            0:       return 8'(lo);
            1:       return 8'(hi);
            default: return 8'(lo + int'($urandom_range(hi - lo)));
        endcase
    endfunction

    function automatic logic [15:0] pick_value();
        case ($urandom_range(7))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'hFFFF;
            3:       return 16'h0000;
            4:       return 16'($urandom_range(1000));
            5:       return 16'h8000 | 16'($urandom_range(400));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    // One pulse transfer; valid stays high into the next call unless a gap is drawn
    task automatic send_pulse(input logic [7:0] pw, input logic start);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pw;
        s_axis_tuser  <= start;
        do
            @(posedge clk);
        while (!s_axis_tready);
        decode_pulse(pw, start);
        pulses_sent++;
    endtask

    // First n_bits of a frame, MSB first; a bad frame gets a corrupted checksum
    task automatic send_frame(input logic [15:0] hum, input logic [15:0] temp,
                              input bit good, input int n_bits, input bit first_start);
        logic [7:0]  sum;
        logic [39:0] frame;
        sum = hum[7:0] + hum[15:8] + temp[7:0] + temp[15:8];
        if (!good)
            sum = sum ^ 8'($urandom_range(255, 1));
        frame = {hum, temp, sum};
        for (int i = 39; i >= 40 - n_bits; i--)
            send_pulse(pulse_for(frame[i]), (i == 39) ? first_start : 1'b0);
    endtask

    // Quiesce input, let every reading drain and the pipeline empty
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (expected_readings.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // All three registers, written back to back while the block is idle
    task automatic apply_settings(input logic signed [7:0] thr, input logic [8:0] ha,
                                  input logic [8:0] ta);
        settle();
        cfg_we    <= 1'b1;
        cfg_index <= hsfd_pkg::CFG_IDX_THRESHOLD;
        cfg_data  <= 9'(thr);
        @(posedge clk);
        cfg_index <= hsfd_pkg::CFG_IDX_HUM_ALPHA;
        cfg_data  <= ha;
        @(posedge clk);
        cfg_index <= hsfd_pkg::CFG_IDX_TEMP_ALPHA;
        cfg_data  <= ta;
        @(posedge clk);
        cfg_we    <= 1'b0;
        one_above  = thr;
        hum_alpha  = ha;
        temp_alpha = ta;
        @(posedge clk);
    endtask

    // ---------------------------------------------------------------- tests

    // Bad frame before any good one reports zeros; first good frame seeds the filter
    task automatic test_first_frames();
        send_frame(16'd655, 16'd253, 1'b0, 40, 1'b1);
        send_frame(16'd655, 16'd253, 1'b1, 40, 1'b1);
        send_frame(16'd700, 16'h8000 | 16'd55, 1'b1, 40, 1'b1);
    endtask

    // Humidity and temperature at their encodings' limits, incl. negative zero
    task automatic test_field_extremes();
        send_frame(16'h7FFF, 16'h7FFF, 1'b1, 40, 1'b1);
        send_frame(16'h8000, 16'h8000, 1'b1, 40, 1'b1);
        send_frame(16'hFFFF, 16'hFFFF, 1'b1, 40, 1'b1);
        send_frame(16'h0000, 16'h0000, 1'b1, 40, 1'b1);
    endtask

    // Partial frames discarded by a new start; back-to-back frame without a start
    task automatic test_frame_restart();
        send_frame(16'd400, 16'd210, 1'b1, 13, 1'b1);
        send_frame(16'd420, 16'd205, 1'b1, 40, 1'b1);
        send_frame(16'd430, 16'd199, 1'b1, 40, 1'b0);
        send_frame(16'd999, 16'd999, 1'b1, 39, 1'b1);
        send_frame(16'd440, 16'h8000 | 16'd12, 1'b1, 40, 1'b1);
    endtask

    // Highest threshold gives all-zero frames; lowest makes only -128 a zero bit
    task automatic test_threshold_extremes();
        apply_settings(8'sd127, hsfd_pkg::ALPHA_RESET, hsfd_pkg::ALPHA_RESET);
        send_frame(pick_value(), pick_value(), 1'b1, 40, 1'b1);
        send_frame(pick_value(), pick_value(), 1'b0, 40, 1'b1);
        apply_settings(-8'sd128, hsfd_pkg::ALPHA_RESET, hsfd_pkg::ALPHA_RESET);
        send_frame(pick_value(), pick_value(), 1'b1, 40, 1'b1);
        send_frame(pick_value(), pick_value(), 1'b0, 40, 1'b1);
        send_frame(16'h1234, 16'h8765, 1'b1, 40, 1'b1);
    endtask

    // Alpha 0 follows the input, 256 holds, 511 extrapolates into saturation
    task automatic test_alpha_extremes();
        apply_settings(8'sd30, 9'd0, 9'd0);
        send_frame(16'd512, 16'h8000 | 16'd100, 1'b1, 40, 1'b1);
        send_frame(16'h7FFF, 16'h7FFF, 1'b1, 40, 1'b1);
        apply_settings(8'sd30, 9'd256, 9'd256);
        send_frame(16'h8000, 16'hFFFF, 1'b1, 40, 1'b1);
        apply_settings(8'sd30, 9'd511, 9'd511);
        send_frame(16'h8000, 16'hFFFF, 1'b1, 40, 1'b1);
        send_frame(16'h7FFF, 16'h7FFF, 1'b1, 40, 1'b1);
        send_frame(16'h8000, 16'hFFFF, 1'b1, 40, 1'b1);
        apply_settings(8'sd30, 9'd300, 9'd1);
        send_frame(pick_value(), pick_value(), 1'b1, 40, 1'b1);
    endtask

    // Error count climbs over consecutive bad frames, then one good frame clears it
    task automatic test_error_count();
        apply_settings(hsfd_pkg::THRESHOLD_RESET, hsfd_pkg::ALPHA_RESET,
                       hsfd_pkg::ALPHA_RESET);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (2)
            send_frame(16'($urandom), 16'($urandom), 1'b0, 40, 1'b1);
        send_frame(16'd555, 16'd222, 1'b1, 40, 1'b1);
    endtask

    // Receiver holds off for a long stretch; the block fills and stalls its input
    task automatic test_back_pressure();
        settle();
        hold_len = HOLD_CYCLES;
        hold_req++;
        repeat (6)
            send_frame(pick_value(), pick_value(), $urandom_range(3) != 0, 40, 1'b1);
    endtask

    // Mostly well-formed frames, some broken ones and some raw noise
    task automatic random_burst(input int n_items, input int n_frames);
        int start_pulses;
        int start_frames;
        int pick;
        start_pulses = pulses_sent;
        start_frames = frames_closed;
        while (pulses_sent - start_pulses < n_items || frames_closed - start_frames < n_frames)
        begin
            pick = $urandom_range(99);
            if (pick < 75)
                send_frame(pick_value(), pick_value(), $urandom_range(9) < 7, 40,
                           $urandom_range(7) != 0);
            else if (pick < 88)
                send_frame(pick_value(), pick_value(), 1'b1, $urandom_range(39, 1), 1'b1);
            else
                repeat ($urandom_range(10, 1))
                    send_pulse(8'($urandom), $urandom_range(7) == 0);
        end
    endtask

    task automatic test_random_traffic();
        apply_settings(hsfd_pkg::THRESHOLD_RESET, 9'($urandom_range(256)),
                       9'($urandom_range(256)));
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        random_burst(50, 1);

        apply_settings(8'($urandom_range(80) - 40), 9'($urandom_range(256)),
                       9'($urandom_range(256)));
        send_idle_pct  = 77;
        recv_stall_pct = 0;
        random_burst(50, 1);

        apply_settings(8'($urandom_range(160) - 60), 9'($urandom_range(256)),
                       9'($urandom_range(256)));
        send_idle_pct  = 0;
        recv_stall_pct = 77;
        random_burst(50, 1);

        apply_settings(8'($urandom_range(80) - 20), 9'($urandom_range(511)),
                       9'($urandom_range(511)));
        send_idle_pct  = 36;
        recv_stall_pct = 36;
        random_burst(50, 1);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    // ---------------------------------------------------------------- receiver, checker

    always @(posedge clk)
    begin
        if (hold_req != hold_ack)
        begin
            hold_ack      <= hold_req;
            hold_left     <= hold_len;
            m_axis_tready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin : result_check
        reading_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_readings.size() == 0)
                report_mismatch("reading transfer with none expected");
            else
            begin
                want = expected_readings.pop_front();
                if (m_axis_tuser)
                    good_seen++;
                else
                    bad_seen++;
                if (m_axis_tuser !== want.ok)
                    report_mismatch($sformatf("checksum_ok %b want %b", m_axis_tuser, want.ok));
                if (m_axis_tdata[15:0] !== want.hum)
                    report_mismatch($sformatf("humidity_tenths %h want %h",
                                              m_axis_tdata[15:0], want.hum));
                if (m_axis_tdata[31:16] !== want.temp)
                    report_mismatch($sformatf("temperature_tenths %h want %h",
                                              m_axis_tdata[31:16], want.temp));
                if (m_axis_tdata[44:32] !== want.hum_whole)
                    report_mismatch($sformatf("humidity_whole %h want %h",
                                              m_axis_tdata[44:32], want.hum_whole));
                if (m_axis_tdata[57:45] !== want.temp_whole)
                    report_mismatch($sformatf("temperature_whole %h want %h",
                                              m_axis_tdata[57:45], want.temp_whole));
                if (m_axis_tdata[65:58] !== want.fails)
                    report_mismatch($sformatf("error_count %h want %h",
                                              m_axis_tdata[65:58], want.fails));
                if (m_axis_tdata[71:66] !== '0)
                    report_mismatch($sformatf("padding %b not zero", m_axis_tdata[71:66]));
            end
        end
    end

    // Input stalls for the summary; quiet cycles for the watchdog
    always @(posedge clk)
    begin
        if (s_axis_tvalid && !s_axis_tready)
            stall_cycles <= stall_cycles + 1;
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        do
            @(posedge clk);
        while (quiet_cycles < QUIET_LIMIT);
        $display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
        $display("tb: errors");
        $finish;
    end

    // ---------------------------------------------------------------- sequence

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_first_frames();
        test_field_extremes();
        test_frame_restart();
        test_threshold_extremes();
        test_alpha_extremes();
        test_error_count();
        test_back_pressure();
        test_random_traffic();

        settle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (expected_readings.size() != 0)
            report_mismatch($sformatf("%0d readings never arrived", expected_readings.size()));

        $display("run: %0d pulse transfers, %0d readings (%0d good, %0d bad checksum)",
                 pulses_sent, good_seen + bad_seen, good_seen, bad_seen);
        $display("run: threshold/alpha extremes, error count, restarts, %0d stall cycles",
                 stall_cycles);
        if (mismatches == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule

// ----- humidity_sensor_frame_decoder_unit.f -----
src/hsfd_pkg.sv
src/hsfd_frame_shift.sv
src/hsfd_filter.sv
src/hsfd_out.sv
src/humidity_sensor_frame_decoder_unit.sv
test/tb.sv
